[rtl/assert_macros.svh]
// Assertion helpers. Every check is sampled on the rising clock edge and
// is switched off while the synchronous reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dtd_pkg.sv]
`default_nettype none
package dtd_pkg;

  localparam int unsigned SampleW  = 8;
  localparam int unsigned LevelW   = 6;
  localparam int unsigned ThrW     = 6;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ThrW-1:0]   JumpThrRst  = 6'd10;
  localparam logic [CountW-1:0] ArmCntRst   = 8'd45;
  localparam logic [CountW-1:0] ConfCntRst  = 8'd40;
  localparam logic [CountW-1:0] TapCountMax = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_JUMP_THRESHOLD = 2'd0,
    REG_ARM_COUNT      = 2'd1,
    REG_CONFIRM_COUNT  = 2'd2
  } cfg_reg_t;

endpackage
`default_nettype wire

[rtl/double_tap_detector_core.sv]
// Double tap detector for a stream of accelerometer Z samples.
// Input channel (in_valid/in_ready): one beat carries a signed 8-bit sample
// and a flag that marks the last sample of a read burst. Each beat lands in
// an input register and is evaluated in the following cycle against the
// stored level, countdown and sign, which are updated in that same cycle.
// Result channel (out_valid/out_ready): one beat with the burst's tap count
// is produced for every sample flagged as last; other samples give none.
// A result goes through the input, then the output register. Throughput is
// one sample per cycle while not stalled, set by the single update stage
// of the state loop. The output register frees the input side: samples
// that do not end a burst keep flowing while a result waits. Only a
// burst-ending sample waits in the input register until the pending
// result is taken, which then holds off further input beats.
// Configuration (cfg_valid/cfg_ready): always ready; index 0 is the jump
// threshold, 1 the arm count, 2 the confirm count. Write only while idle.
// Reset (synchronous, active low) restores the register defaults and clears
// the level, countdown, sign, tap count and both valid flags.
`default_nettype none
`include "assert_macros.svh"
module double_tap_detector_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [dtd_pkg::SampleW-1:0]   in_sample,
  input  wire logic                                 in_last_of_burst,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic        [dtd_pkg::CountW-1:0]         out_tap_total,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic   [dtd_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire logic   [dtd_pkg::CfgDataW-1:0]       cfg_data
);

  logic [dtd_pkg::ThrW-1:0]   jump_thr_r;
  logic [dtd_pkg::CountW-1:0] arm_cnt_r;
  logic [dtd_pkg::CountW-1:0] conf_cnt_r;

  logic                                s1_valid_r;
  logic signed [dtd_pkg::SampleW-1:0]  s1_sample_r;
  logic                                s1_last_r;
  logic                                s1_adv;

  logic signed [dtd_pkg::LevelW-1:0]   prev_level_r;
  logic [dtd_pkg::CountW-1:0]          countdown_r, countdown_nxt;
  logic                                first_pos_r, first_pos_nxt;
  logic [dtd_pkg::CountW-1:0]          taps_r, taps_nxt, taps_inc;

  logic                                out_valid_r;
  logic [dtd_pkg::CountW-1:0]          out_tap_r;

  logic signed [dtd_pkg::LevelW-1:0]   level;
  logic signed [dtd_pkg::LevelW+1:0]   diff;
  logic signed [dtd_pkg::LevelW+1:0]   thr_pos;
  logic signed [dtd_pkg::LevelW+1:0]   thr_neg;
  logic                                jump_up;
  logic                                jump_down;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_thr_r <= dtd_pkg::JumpThrRst;
      arm_cnt_r  <= dtd_pkg::ArmCntRst;
      conf_cnt_r <= dtd_pkg::ConfCntRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        dtd_pkg::REG_JUMP_THRESHOLD: jump_thr_r <= cfg_data[dtd_pkg::ThrW-1:0];
        dtd_pkg::REG_ARM_COUNT:      arm_cnt_r  <= cfg_data;
        dtd_pkg::REG_CONFIRM_COUNT:  conf_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A burst-ending sample may only leave the input register when the
  // output register is free or being emptied in this cycle.
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample;
      s1_last_r   <= in_last_of_burst;
    end
  end

  always_comb begin
    level     = s1_sample_r[dtd_pkg::SampleW-1:2];
    diff      = {{2{level[dtd_pkg::LevelW-1]}}, level}
              - {{2{prev_level_r[dtd_pkg::LevelW-1]}}, prev_level_r};
    thr_pos   = {2'b00, jump_thr_r};
    thr_neg   = -thr_pos;
    jump_up   = diff > thr_pos;
    jump_down = diff < thr_neg;
  end

  always_comb begin
    countdown_nxt = countdown_r;
    first_pos_nxt = first_pos_r;
    taps_inc      = taps_r;
    if (countdown_r == '0) begin
      if (jump_up || jump_down) begin
        countdown_nxt = arm_cnt_r;
        first_pos_nxt = jump_up;
      end
    end else if (countdown_r > conf_cnt_r) begin
      if ((jump_up && !first_pos_r) || (jump_down && first_pos_r)) begin
        if (taps_r != dtd_pkg::TapCountMax) begin
          taps_inc = taps_r + 1'b1;
        end
        countdown_nxt = conf_cnt_r;
      end else begin
        countdown_nxt = countdown_r - 1'b1;
      end
    end else begin
      countdown_nxt = countdown_r - 1'b1;
    end
    taps_nxt = s1_last_r ? '0 : taps_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= '0;
      countdown_r  <= '0;
      first_pos_r  <= 1'b0;
      taps_r       <= '0;
    end else if (s1_adv) begin
      prev_level_r <= level;
      countdown_r  <= countdown_nxt;
      first_pos_r  <= first_pos_nxt;
      taps_r       <= taps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_tap_r <= taps_inc;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tap_total = out_tap_r;

  `ASSERT_NEXT(a_countdown_falls, s1_adv && countdown_r != '0,
    countdown_r < $past(countdown_r), "armed countdown did not fall")
  `ASSERT_NEXT(a_result_follows_last, s1_adv && s1_last_r,
    out_valid_r, "no result after a burst-ending sample")
  `ASSERT_NEXT(a_taps_cleared, s1_adv && s1_last_r,
    taps_r == '0, "tap count not cleared at burst end")

endmodule
`default_nettype wire
